// ===== design/rds_pkg.sv =====
// ----------------------------------------------------------------------------
// rds_pkg
// Shared widths, defaults, status types and helpers for the running delta
// similarity block.
// ----------------------------------------------------------------------------
package rds_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int SAMPLE_W       = 32;
  localparam int TOT_W          = 64;
  localparam int ACC_W          = 64;
  localparam int ABS_W          = 50;
  localparam int SIM_W          = 48;
  localparam int PAIRS_W        = 32;
  localparam int MUL_B_W        = 25;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Signed add that clamps at the 64 bit limits.
  function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0] a, input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
      s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s;
  endfunction

  // Unsigned add that clamps at all ones.
  function automatic logic [ABS_W-1:0] abs_add(
      input logic [ABS_W-1:0] a, input logic [ABS_W-1:0] b);
    logic [ABS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ABS_W] ? {ABS_W{1'b1}} : s[ABS_W-1:0];
  endfunction

endpackage

// ===== design/rds_div.sv =====
// ----------------------------------------------------------------------------
// rds_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rds_div #(
  parameter int N = 84,
  parameter int D = 76
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [N-1:0]        dividend,
  input  logic [D-1:0]        divisor,
  output rds_pkg::div_stat_t  stat,
  output logic [N-1:0]        quot,
  output logic                rem_nz
);

  localparam int CW = $clog2(N + 1);

  logic [N-1:0]  quo_r, quo_nxt;
  logic [D-1:0]  rem_r, rem_nxt;
  logic [D-1:0]  den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [D:0]    trial, diff;
  logic          ge;

  always_comb begin
    trial   = {rem_r, quo_r[N-1]};
    diff    = trial - {1'b0, den_r};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? diff[D-1:0] : trial[D-1:0];
    quo_nxt = {quo_r[N-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(N);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quo_r;
  assign rem_nz    = |rem_r;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r)) else $error("done without a run");
  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held longer than a cycle");
`endif

endmodule

// ===== design/running_delta_similarity_core.sv =====
// ----------------------------------------------------------------------------
// running_delta_similarity_core
// Running delta similarity of two Q-format sample series.
// ----------------------------------------------------------------------------
// Each input beat carries one (x, y) sample pair. The block keeps a pair
// count, running sums, absolute delta sums and a similarity accumulator, and
// answers every pair with one result beat: accumulator / (count - 1), zero for
// the first pair, and the count. All divisions go through one shared
// restoring divider of NUM_W = (34 - FRAC_BITS) + ABS_W + FRAC_BITS = 84 bits
// at the default widths, one quotient bit a cycle, and each divider pass also
// takes an issue and a done step. A pair with both deltas nonzero makes four
// passes (mean of x, mean of y, the ratio of scaled deltas, the final
// average) plus the delta, compare, update and output steps and four
// multiply steps. A pair with a zero delta skips the multiply, compare and
// ratio steps; the first pair also skips the final average. in_stall is
// high while a pair is in work, and a finished result that finds the output
// register still full holds the block until the waiting beat leaves. A
// finished result waits in the output register and the next pair is taken
// meanwhile. When the count has saturated a pair is dropped and the result
// is reported from the held state.
// ----------------------------------------------------------------------------
module running_delta_similarity_core #(
  parameter int COUNT_BITS = rds_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = rds_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [rds_pkg::SAMPLE_W-1:0]    in_sample_x,
  input  logic signed [rds_pkg::SAMPLE_W-1:0]    in_sample_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [rds_pkg::SIM_W-1:0]       out_similarity,
  output logic [rds_pkg::PAIRS_W-1:0]            out_pairs_seen
);

  localparam int TW    = rds_pkg::TOT_W;
  localparam int AW    = rds_pkg::ACC_W;
  localparam int BW    = rds_pkg::ABS_W;
  localparam int MB    = rds_pkg::MUL_B_W;
  localparam int MAG_W = 34 - FRAC_BITS;           // |delta| width
  localparam int DEN_W = MAG_W + BW;               // scaled delta width
  localparam int NUM_W = DEN_W + FRAC_BITS;        // divider width
  localparam int DW    = TW + 2;                   // delta arithmetic width
  localparam int SW    = rds_pkg::SIM_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DX, ST_DY, ST_DELTA, ST_MUL, ST_CMP, ST_RATIO, ST_UPD,
    ST_FIN, ST_OUT
  } state_t;

  state_t state_r;

  logic [COUNT_BITS-1:0]    count_r;
  logic signed [TW-1:0]     tot_x_r, tot_y_r;
  logic [BW-1:0]            abs_x_r, abs_y_r;
  logic signed [AW-1:0]     acc_r, m_r;
  logic signed [rds_pkg::SAMPLE_W-1:0] sx_r, sy_r;
  logic signed [TW-1:0]     qx_r, qy_r;
  logic                     rx_r, ry_r;
  logic [MAG_W-1:0]         dmx_r, dmy_r;
  logic                     dnx_r, dny_r;
  logic [DEN_W-1:0]         px_r, py_r;
  logic [1:0]               mstep_r;
  logic                     xg_r;
  logic                     go_r;
  logic                     out_valid_r;
  logic signed [SW-1:0]     sim_r, out_sim_r;
  logic [rds_pkg::PAIRS_W-1:0] out_pairs_r;

  // Shared divider
  rds_pkg::div_stat_t       dstat;
  logic [NUM_W-1:0]         div_a, quot;
  logic [DEN_W-1:0]         div_b;
  logic                     rem_nz;

  logic                     in_acc, out_acc, count_full;
  logic [TW-1:0]            mag_tx, mag_ty, mag_acc;
  logic signed [TW-1:0]     q_floor;
  logic [MAG_W-1:0]         dm_x, dm_y;
  logic                     dn_x, dn_y;
  logic [BW-1:0]            ax_e, ay_e;
  logic [MAG_W-1:0]         mul_a;
  logic [BW-1:0]            mul_bf;
  logic [MB-1:0]            mul_b;
  logic [MAG_W+MB-1:0]      prod;
  logic [TW-1:0]            rmag;
  logic signed [SW-1:0]     sim_fin;
  logic [TW-1:0]            qf;

  assign in_acc     = in_valid && !in_stall;
  assign out_acc    = out_valid_r && !out_stall;
  assign in_stall   = (state_r != ST_IDLE);
  assign count_full = (count_r == {COUNT_BITS{1'b1}});

  assign mag_tx  = tot_x_r[TW-1] ? TW'(-tot_x_r) : TW'(tot_x_r);
  assign mag_ty  = tot_y_r[TW-1] ? TW'(-tot_y_r) : TW'(tot_y_r);
  assign mag_acc = acc_r[AW-1] ? TW'(-acc_r) : TW'(acc_r);

  // Route operands to the divider by phase
  always_comb begin
    case (state_r)
      ST_DX: begin
        div_a = NUM_W'(mag_tx);
        div_b = DEN_W'(count_r);
      end
      ST_DY: begin
        div_a = NUM_W'(mag_ty);
        div_b = DEN_W'(count_r);
      end
      ST_RATIO: begin
        div_a = {(xg_r ? py_r : px_r), {FRAC_BITS{1'b0}}};
        div_b = xg_r ? px_r : py_r;
      end
      ST_FIN: begin
        div_a = NUM_W'(mag_acc);
        div_b = DEN_W'(count_r - 1'b1);
      end
      default: begin
        div_a = '0;
        div_b = '0;
      end
    endcase
  end

  rds_div #(.N(NUM_W), .D(DEN_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (go_r),
    .dividend (div_a),
    .divisor  (div_b),
    .stat     (dstat),
    .quot     (quot),
    .rem_nz   (rem_nz)
  );

  // Floor of the mean from the truncated magnitude quotient
  always_comb begin
    logic neg;
    logic [TW-1:0] q0;
    neg = (state_r == ST_DX) ? tot_x_r[TW-1] : tot_y_r[TW-1];
    q0  = quot[TW-1:0];
    if (!neg)        q_floor = q0;
    else if (rem_nz) q_floor = ~q0;
    else             q_floor = -q0;
  end

  // Round half away from zero of sample minus floor(mean)
  function automatic logic [MAG_W:0] round_delta(
      input logic signed [rds_pkg::SAMPLE_W-1:0] s,
      input logic signed [TW-1:0] q, input logic rnz);
    logic signed [DW-1:0] d, e, half;
    half = DW'(1) <<< (FRAC_BITS - 1);
    d    = DW'(s) - DW'(q);
    if (d > 0) begin
      e = d + half - DW'(rnz);
      return {1'b0, e[FRAC_BITS +: MAG_W]};
    end else begin
      e = half - d;
      return {d[DW-1], e[FRAC_BITS +: MAG_W]};
    end
  endfunction

  always_comb begin
    {dn_x, dm_x} = round_delta(sx_r, qx_r, rx_r);
    {dn_y, dm_y} = round_delta(sy_r, qy_r, ry_r);
  end

  // Scale each delta by the other series' absolute sum, 25 bits a step
  assign ax_e   = (abs_x_r == '0) ? BW'(1) : abs_x_r;
  assign ay_e   = (abs_y_r == '0) ? BW'(1) : abs_y_r;
  assign mul_a  = mstep_r[1] ? dmy_r : dmx_r;
  assign mul_bf = mstep_r[1] ? ax_e : ay_e;
  assign mul_b  = mstep_r[0] ? mul_bf[BW-1:MB] : mul_bf[MB-1:0];
  assign prod   = (MAG_W+MB)'(mul_a) * (MAG_W+MB)'(mul_b);

  // Ratio magnitude, clamped where the quotient reaches bit 63
  assign rmag = (|quot[NUM_W-1:TW-1]) ? {1'b0, {(TW-1){1'b1}}} : {1'b0, quot[TW-2:0]};

  // Final average, clamped to the result width
  assign qf = quot[TW-1:0];
  always_comb begin
    if (!acc_r[AW-1]) begin
      sim_fin = (qf > TW'({1'b0, {(SW-1){1'b1}}})) ? {1'b0, {(SW-1){1'b1}}}
                                                   : qf[SW-1:0];
    end else begin
      sim_fin = (qf >= (TW'(1) << (SW-1))) ? {1'b1, {(SW-1){1'b0}}}
                                           : -qf[SW-1:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      tot_x_r     <= '0;
      tot_y_r     <= '0;
      abs_x_r     <= '0;
      abs_y_r     <= '0;
      acc_r       <= '0;
      mstep_r     <= '0;
    end else begin
      go_r <= 1'b0;
      // Drop the beat once taken, unless a new one replaces it this cycle
      if (out_acc && state_r != ST_OUT) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (count_full) begin
              // Drop the pair, report from held state
              state_r <= ST_FIN;
              go_r    <= 1'b1;
            end else begin
              count_r <= count_r + 1'b1;
              tot_x_r <= tot_x_r + TW'(in_sample_x);
              tot_y_r <= tot_y_r + TW'(in_sample_y);
              sx_r    <= in_sample_x;
              sy_r    <= in_sample_y;
              state_r <= ST_DX;
              go_r    <= 1'b1;
            end
          end
        end
        ST_DX: begin
          if (dstat.done) begin
            qx_r    <= q_floor;
            rx_r    <= rem_nz;
            state_r <= ST_DY;
            go_r    <= 1'b1;
          end
        end
        ST_DY: begin
          if (dstat.done) begin
            qy_r    <= q_floor;
            ry_r    <= rem_nz;
            state_r <= ST_DELTA;
          end
        end
        ST_DELTA: begin
          dmx_r <= dm_x;
          dmy_r <= dm_y;
          dnx_r <= dn_x;
          dny_r <= dn_y;
          if (dm_x != '0 && dm_y != '0) begin
            mstep_r <= '0;
            state_r <= ST_MUL;
          end else begin
            m_r <= (dm_x == '0 && dm_y == '0 && count_r > COUNT_BITS'(1))
                   ? (AW'(1) <<< FRAC_BITS) : '0;
            state_r <= ST_UPD;
          end
        end
        ST_MUL: begin
          case (mstep_r)
            2'd0:    px_r <= DEN_W'(prod);
            2'd1:    px_r <= px_r + (DEN_W'(prod) << MB);
            2'd2:    py_r <= DEN_W'(prod);
            default: py_r <= py_r + (DEN_W'(prod) << MB);
          endcase
          mstep_r <= mstep_r + 1'b1;
          if (mstep_r == 2'd3) state_r <= ST_CMP;
        end
        ST_CMP: begin
          // Pick the larger scaled delta as divisor
          if (dnx_r != dny_r)  xg_r <= !dnx_r;
          else if (!dnx_r)     xg_r <= (px_r > py_r);
          else                 xg_r <= (py_r > px_r);
          state_r <= ST_RATIO;
          go_r    <= 1'b1;
        end
        ST_RATIO: begin
          if (dstat.done) begin
            m_r     <= (dnx_r != dny_r) ? -AW'(rmag) : AW'(rmag);
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          acc_r   <= rds_pkg::sat_add(acc_r, m_r);
          abs_x_r <= rds_pkg::abs_add(abs_x_r, BW'(dmx_r));
          abs_y_r <= rds_pkg::abs_add(abs_y_r, BW'(dmy_r));
          if (count_r >= COUNT_BITS'(2)) begin
            state_r <= ST_FIN;
            go_r    <= 1'b1;
          end else begin
            sim_r   <= '0;
            state_r <= ST_OUT;
          end
        end
        ST_FIN: begin
          if (dstat.done) begin
            sim_r   <= sim_fin;
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          // Hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_sim_r   <= sim_r;
            out_pairs_r <= rds_pkg::PAIRS_W'(count_r);
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_similarity = out_sim_r;
  assign out_pairs_seen = out_pairs_r;

`ifndef NO_ASSERTIONS
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !count_full |=> count_r == $past(count_r) + 1'b1)
    else $error("pair count did not advance");
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && count_full |=> $stable(tot_x_r) && $stable(tot_y_r) && $stable(acc_r))
    else $error("dropped pair changed state");
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    go_r |-> !dstat.busy) else $error("divider issued while busy");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT && out_valid_r && out_stall |=> state_r == ST_OUT)
    else $error("result overwrote a waiting beat");
`endif

endmodule
